// ===== src/stack_with_purge_macros.svh =====
// ----------------------------------------------------------------------------
// stack_with_purge assertion macros
// Shared concurrent assertion forms for the purging stack.
// ----------------------------------------------------------------------------
`ifndef STACK_WITH_PURGE_MACROS_SVH
`define STACK_WITH_PURGE_MACROS_SVH

// Check a condition at every clock edge outside reset
`define SWS_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check a consequent in the same cycle as its antecedent
`define SWS_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequent in the cycle after its antecedent
`define SWS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/sws_pkg.sv =====
// ----------------------------------------------------------------------------
// sws_pkg
// Types and constants shared by the purging stack modules.
// ----------------------------------------------------------------------------
package sws_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int DATA_W    = 32;
    localparam int LEVEL_W   = 7;

    typedef enum logic [1:0] {
        ACT_PUSH  = 2'd0,
        ACT_POP   = 2'd1,
        ACT_TOP   = 2'd2,
        ACT_PURGE = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_PURGE
    } state_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] data;
        status_t                  status;
        logic [LEVEL_W-1:0]       level;
    } result_t;

endpackage

// ===== src/stack_with_purge.sv =====
// Push and refused actions: result registered in the cycle after acceptance. Pop and top:
// registered store read, then result register. A purge reads and compacts one store entry
// a cycle. One action at a time; pushes and refused actions every cycle while out_stall is
// low. Next transfer taken once the sequencer idles and the result register is empty or
// draining. Reset clears fill level, sequencer and result valid, not the stored words.
// ----------------------------------------------------------------------------
// stack_with_purge
// Bounded LIFO of signed words with push, pop, top and purge by value.
// ----------------------------------------------------------------------------
`include "stack_with_purge_macros.svh"

module stack_with_purge
    import sws_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [1:0]                action,
    input  logic signed [DATA_W-1:0]  value,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic signed [DATA_W-1:0]  data_out,
    output logic [1:0]                status,
    output logic [LEVEL_W-1:0]        level
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic                     mem_we;
    logic [AW-1:0]            mem_waddr;
    logic signed [DATA_W-1:0] mem_wdata;
    logic [AW-1:0]            mem_raddr;
    logic signed [DATA_W-1:0] mem_rdata;
    result_t                  result;
    logic                     busy;
    logic [CW-1:0]            fill;
    logic                     push_ok;

    sws_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .action    (action_t'(action)),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .result    (result),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata),
        .busy      (busy),
        .fill      (fill)
    );

    sws_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign data_out = result.data;
    assign status   = result.status;
    assign level    = result.level;

    assign push_ok = in_valid && !in_stall && action == ACT_PUSH && fill != CW'(DEPTH);

    `SWS_ASSERT_ALWAYS(a_fill_bound, clk, rst_n, fill <= CW'(DEPTH), "fill level beyond depth")
    `SWS_ASSERT_IMPLY(a_busy_stall, clk, rst_n, busy, in_stall, "transfer taken while busy")
    `SWS_ASSERT_IMPLY(a_busy_no_result, clk, rst_n, busy, !out_valid, "result pending while busy")
    `SWS_ASSERT_NEXT(a_push_grows, clk, rst_n, push_ok, fill == $past(fill) + CW'(1), "push lost")

endmodule

// ===== src/sws_mem.sv =====
// ----------------------------------------------------------------------------
// sws_mem
// Entry store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module sws_mem
    import sws_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [AW-1:0]            waddr,
    input  logic signed [DATA_W-1:0] wdata,
    input  logic [AW-1:0]            raddr,
    output logic signed [DATA_W-1:0] rdata
);

    logic signed [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ===== src/sws_ctrl.sv =====
// ----------------------------------------------------------------------------
// sws_ctrl
// Sequencer for push, pop, top and purge, with the result register.
// ----------------------------------------------------------------------------
module sws_ctrl
    import sws_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH),
    parameter int CW    = $clog2(DEPTH + 1)
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  action_t                  action,
    input  logic signed [DATA_W-1:0] value,
    output logic                     out_valid,
    input  logic                     out_stall,
    output result_t                  result,
    output logic                     mem_we,
    output logic [AW-1:0]            mem_waddr,
    output logic signed [DATA_W-1:0] mem_wdata,
    output logic [AW-1:0]            mem_raddr,
    input  logic signed [DATA_W-1:0] mem_rdata,
    output logic                     busy,
    output logic [CW-1:0]            fill
);

    state_t                   state_reg, state_next;
    logic [CW-1:0]            fill_reg, fill_next;
    logic [AW-1:0]            scan_reg, scan_next;
    logic [CW-1:0]            kept_reg, kept_next;
    logic signed [DATA_W-1:0] key_reg, key_next;
    logic                     out_valid_reg, out_valid_next;
    result_t                  out_reg, out_next;

    logic                     out_free;
    logic                     accept;
    logic                     is_empty;
    logic                     is_full;
    logic                     last;
    logic                     hit;
    logic [CW-1:0]            kept_inc;
    logic [AW-1:0]            top_addr;
    logic                     out_load;

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != ST_IDLE) || !out_free;
    assign accept   = in_valid && !in_stall;
    assign is_empty = (fill_reg == '0);
    assign is_full  = (fill_reg == CW'(DEPTH));
    assign top_addr = AW'(fill_reg - CW'(1));
    assign last     = (CW'(scan_reg) + CW'(1)) == fill_reg;
    assign hit      = (mem_rdata == key_reg);
    assign kept_inc = hit ? kept_reg : kept_reg + CW'(1);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && !is_empty)
                begin
                    if (action inside {ACT_POP, ACT_TOP})
                    begin
                        state_next = ST_READ;
                    end
                    else if (action == ACT_PURGE)
                    begin
                        state_next = ST_PURGE;
                    end
                end
            end
            ST_READ:
            begin
                state_next = ST_IDLE;
            end
            ST_PURGE:
            begin
                if (last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        fill_next = fill_reg;
        scan_next = scan_reg;
        kept_next = kept_reg;
        key_next  = key_reg;
        mem_we    = 1'b0;
        mem_waddr = AW'(fill_reg);
        mem_wdata = value;
        mem_raddr = top_addr;
        out_load  = 1'b0;
        out_next  = out_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (action)
                        ACT_PUSH:
                        begin
                            out_load = 1'b1;
                            if (is_full)
                            begin
                                out_next = '{data: '0, status: STAT_FULL,
                                             level: LEVEL_W'(fill_reg)};
                            end
                            else
                            begin
                                mem_we    = 1'b1;
                                fill_next = fill_reg + CW'(1);
                                out_next  = '{data: '0, status: STAT_OK,
                                              level: LEVEL_W'(fill_reg + CW'(1))};
                            end
                        end
                        ACT_POP, ACT_TOP:
                        begin
                            if (is_empty)
                            begin
                                out_load = 1'b1;
                                out_next = '{data: '0, status: STAT_EMPTY, level: '0};
                            end
                            else if (action == ACT_POP)
                            begin
                                fill_next = fill_reg - CW'(1);
                            end
                        end
                        ACT_PURGE:
                        begin
                            key_next  = value;
                            scan_next = '0;
                            kept_next = '0;
                            mem_raddr = '0;
                            if (is_empty)
                            begin
                                out_load = 1'b1;
                                out_next = '{data: '0, status: STAT_OK, level: '0};
                            end
                        end
                        default:
                        begin
                            out_load = 1'b0;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                out_load = 1'b1;
                out_next = '{data: mem_rdata, status: STAT_OK,
                             level: LEVEL_W'(fill_reg)};
            end
            ST_PURGE:
            begin
                mem_we    = !hit;
                mem_waddr = AW'(kept_reg);
                mem_wdata = mem_rdata;
                kept_next = kept_inc;
                scan_next = scan_reg + AW'(1);
                mem_raddr = scan_reg + AW'(1);
                if (last)
                begin
                    fill_next = kept_inc;
                    out_load  = 1'b1;
                    out_next  = '{data: DATA_W'(fill_reg - kept_inc), status: STAT_OK,
                                  level: LEVEL_W'(kept_inc)};
                end
            end
            default:
            begin
                out_load = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            scan_reg      <= '0;
            kept_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            scan_reg      <= scan_next;
            kept_reg      <= kept_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        if (out_load)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = out_reg;
    assign busy      = (state_reg != ST_IDLE);
    assign fill      = fill_reg;

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the purging stack.
// A directed table covers empty reads and purges, and then over a thousand
// random actions run in bursts that fill, mix, purge and drain. A shadow
// stack predicts each result the table does not give. Both sides idle at
// random, and the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb;
    import sws_pkg::*;

    localparam int DEPTH        = DEPTH_DEF;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_ITEMS = 1100;
    localparam int HOLD_AT      = 150;
    localparam int HOLD_CYCLES  = 300;
    localparam int MAX_PRINTS   = 40;

    typedef struct {
        action_t                  act;
        logic signed [DATA_W-1:0] val;
        bit                       typed;
        result_t                  want;
    } stim_row_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic [1:0]               action = ACT_PUSH;
    logic signed [DATA_W-1:0] value = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic signed [DATA_W-1:0] data_out;
    logic [1:0]               status;
    logic [LEVEL_W-1:0]       level;

    logic signed [DATA_W-1:0] shadow_words [DEPTH];
    int                       shadow_fill = 0;
    result_t                  pending_results [$];
    stim_row_t                stim_table [$];
    bit                       quiet_sender = 1'b0;

    int mismatches    = 0;
    int results_seen  = 0;
    int transfers_in  = 0;
    int full_refusals = 0;
    int empty_reads   = 0;
    int purge_hits    = 0;
    int peak_fill     = 0;
    int cycle_count   = 0;

    stack_with_purge #(.DEPTH(DEPTH)) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .action    (action),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .data_out  (data_out),
        .status    (status),
        .level     (level)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic result_t stack_action(action_t act, logic signed [DATA_W-1:0] val);
        result_t r;
        int      kept;
        int      i;
        r.data   = '0;
        r.status = STAT_OK;
        case (act)
            ACT_PUSH:
            begin
                if (shadow_fill >= DEPTH)
                begin
                    r.status = STAT_FULL;
                    full_refusals++;
                end
                else
                begin
                    shadow_words[shadow_fill] = val;
                    shadow_fill++;
                end
            end
            ACT_POP, ACT_TOP:
            begin
                if (shadow_fill == 0)
                begin
                    r.status = STAT_EMPTY;
                    empty_reads++;
                end
                else
                begin
                    r.data = shadow_words[shadow_fill - 1];
                    if (act == ACT_POP)
                        shadow_fill--;
                end
            end
            default:
            begin
                kept = 0;
                for (i = 0; i < shadow_fill; i++)
                begin
                    if (shadow_words[i] != val)
                    begin
                        shadow_words[kept] = shadow_words[i];
                        kept++;
                    end
                end
                r.data = DATA_W'(shadow_fill - kept);
                if (kept != shadow_fill)
                    purge_hits++;
                shadow_fill = kept;
            end
        endcase
        r.level = LEVEL_W'(shadow_fill);
        if (shadow_fill > peak_fill)
            peak_fill = shadow_fill;
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_value();
        if ($urandom_range(0, 9) >= 5)
            return $urandom();
        case ($urandom_range(0, 5))
            0:       return 32'sh0000_0000;
            1:       return 32'shFFFF_FFFF;
            2:       return 32'sh7FFF_FFFF;
            3:       return 32'sh8000_0000;
            4:       return 32'sh0000_0007;
            default: return 32'sh0000_002A;
        endcase
    endfunction

    // kind: 0 fill, 1 mixed, 2 purge-heavy, 3 drain
    function automatic action_t pick_action(int kind);
        int r;
        int push_lim;
        int pop_lim;
        int top_lim;
        r = $urandom_range(0, 99);
        case (kind)
            0:       begin push_lim = 92; pop_lim = 92; top_lim = 96; end
            1:       begin push_lim = 40; pop_lim = 65; top_lim = 85; end
            2:       begin push_lim = 55; pop_lim = 65; top_lim = 70; end
            default: begin push_lim = 15; pop_lim = 75; top_lim = 90; end
        endcase
        if (r < push_lim)
            return ACT_PUSH;
        else if (r < pop_lim)
            return ACT_POP;
        else if (r < top_lim)
            return ACT_TOP;
        else
            return ACT_PURGE;
    endfunction

    task automatic add_row(action_t act, logic signed [DATA_W-1:0] val, bit typed,
                           logic signed [DATA_W-1:0] data, status_t stat,
                           logic [LEVEL_W-1:0] lvl);
        stim_row_t row;
        row.act         = act;
        row.val         = val;
        row.typed       = typed;
        row.want.data   = data;
        row.want.status = stat;
        row.want.level  = lvl;
        stim_table.push_back(row);
    endtask

    task automatic report_mismatch(string field, logic [DATA_W-1:0] want,
                                   logic [DATA_W-1:0] got);
        if (mismatches < MAX_PRINTS)
            $display("%0t result %0d %s: expected %0h, got %0h",
                     $realtime, results_seen, field, want, got);
        mismatches++;
    endtask

    task automatic send_transfer(action_t act, logic signed [DATA_W-1:0] val, bit typed,
                                 result_t want);
        int      gap;
        result_t predicted;
        gap = quiet_sender ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        action   <= act;
        value    <= val;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predicted = stack_action(act, val);
        pending_results.push_back(typed ? want : predicted);
        transfers_in++;
    endtask

    initial
    begin : result_check
        result_t want;
        int      hold_left;
        int      stall_left;
        int      local_cycles;
        bit      held;
        bit      quiet_receiver;
        hold_left      = 0;
        stall_left     = 0;
        local_cycles   = 0;
        held           = 1'b0;
        quiet_receiver = 1'b0;
        forever
        begin
            @(posedge clk);
            local_cycles++;
            if (rst_n && out_valid && !out_stall)
            begin
                if (pending_results.size() == 0)
                    report_mismatch("unexpected transfer", '0, data_out);
                else
                begin
                    want = pending_results.pop_front();
                    if (data_out !== want.data)
                        report_mismatch("data_out", want.data, data_out);
                    if (status !== want.status)
                        report_mismatch("status", 32'(want.status), 32'(status));
                    if (level !== want.level)
                        report_mismatch("level", 32'(want.level), 32'(level));
                end
                results_seen++;
            end
            if (local_cycles % 256 == 0)
                quiet_receiver = ($urandom_range(0, 3) == 0);
            if (results_seen == HOLD_AT && !held)
            begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                if (stall_left == 0 && !quiet_receiver)
                    stall_left = pick_gap();
                out_stall <= (stall_left > 0);
                if (stall_left > 0)
                    stall_left--;
            end
        end
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("run stopped after %0d cycles with %0d results outstanding",
                 cycle_count, pending_results.size());
        $display("stack_with_purge: mismatch");
        $finish;
    end

    initial
    begin : stimulus
        stim_row_t row;
        result_t   blank;
        int        burst;
        int        kind;
        int        len;
        int        random_sent;
        blank       = '0;
        burst       = 0;
        random_sent = 0;

        add_row(ACT_POP,   32'sh0000_0000, 1'b1, 32'sd0,          STAT_EMPTY, 7'd0);
        add_row(ACT_TOP,   32'sh0000_0000, 1'b1, 32'sd0,          STAT_EMPTY, 7'd0);
        add_row(ACT_PURGE, 32'sh0000_0000, 1'b1, 32'sd0,          STAT_OK,    7'd0);
        add_row(ACT_PUSH,  32'sh8000_0000, 1'b1, 32'sd0,          STAT_OK,    7'd1);
        add_row(ACT_PUSH,  32'sh7FFF_FFFF, 1'b1, 32'sd0,          STAT_OK,    7'd2);
        add_row(ACT_TOP,   32'sh0000_0000, 1'b1, 32'sh7FFF_FFFF,  STAT_OK,    7'd2);
        add_row(ACT_PUSH,  32'sh0000_0000, 1'b1, 32'sd0,          STAT_OK,    7'd3);
        add_row(ACT_PUSH,  32'shFFFF_FFFF, 1'b1, 32'sd0,          STAT_OK,    7'd4);
        add_row(ACT_PUSH,  32'sh7FFF_FFFF, 1'b1, 32'sd0,          STAT_OK,    7'd5);
        add_row(ACT_PUSH,  32'sh8000_0000, 1'b1, 32'sd0,          STAT_OK,    7'd6);
        add_row(ACT_PUSH,  32'sh0000_0005, 1'b1, 32'sd0,          STAT_OK,    7'd7);
        add_row(ACT_PURGE, 32'sh7FFF_FFFF, 1'b1, 32'sd2,          STAT_OK,    7'd5);
        add_row(ACT_TOP,   32'sh0000_0000, 1'b0, '0, STAT_OK, '0);
        add_row(ACT_PURGE, 32'sh1234_5678, 1'b0, '0, STAT_OK, '0);
        add_row(ACT_POP,   32'shFFFF_FFFF, 1'b0, '0, STAT_OK, '0);
        add_row(ACT_POP,   32'sh0000_0000, 1'b0, '0, STAT_OK, '0);
        add_row(ACT_PURGE, 32'sh8000_0000, 1'b0, '0, STAT_OK, '0);
        add_row(ACT_POP,   32'sh0000_0000, 1'b0, '0, STAT_OK, '0);
        add_row(ACT_POP,   32'sh0000_0000, 1'b0, '0, STAT_OK, '0);
        add_row(ACT_PUSH,  32'sh0000_0001, 1'b0, '0, STAT_OK, '0);
        add_row(ACT_PUSH,  32'sh0000_0001, 1'b0, '0, STAT_OK, '0);
        add_row(ACT_PURGE, 32'sh0000_0001, 1'b0, '0, STAT_OK, '0);
        add_row(ACT_TOP,   32'sh0000_0000, 1'b0, '0, STAT_OK, '0);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stim_table[i])
        begin
            row = stim_table[i];
            send_transfer(row.act, row.val, row.typed, row.want);
        end

        while (random_sent < RANDOM_ITEMS)
        begin
            kind         = burst % 4;
            len          = (kind == 0) ? $urandom_range(70, 90) : $urandom_range(15, 60);
            quiet_sender = ($urandom_range(0, 3) == 0);
            repeat (len)
            begin
                send_transfer(pick_action(kind), pick_value(), 1'b0, blank);
                random_sent++;
            end
            if (burst % 3 == 2 && pending_results.size() != 0)
            begin
                in_valid <= 1'b0;
                while (pending_results.size() != 0)
                    @(posedge clk);
            end
            burst++;
        end

        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DEPTH + 8) @(posedge clk);

        $display("%0d transfers in, %0d results checked, peak fill %0d of %0d",
                 transfers_in, results_seen, peak_fill, DEPTH);
        $display("%0d pushes refused on full, %0d reads on empty, %0d purges removed entries",
                 full_refusals, empty_reads, purge_hits);
        if (mismatches == 0)
            $display("stack_with_purge: match");
        else
            $display("stack_with_purge: mismatch");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+src
src/sws_pkg.sv
src/sws_mem.sv
src/sws_ctrl.sv
src/stack_with_purge.sv
tb/sv/tb.sv
